### src/pdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdm_pkg;

  // metric_select codes
  typedef enum logic [1:0] {
    METRIC_MANHATTAN = 2'd0,
    METRIC_EUCLID    = 2'd1,
    METRIC_CHEBYSHEV = 2'd2,
    METRIC_NONE      = 2'd3
  } metric_t;

  localparam int unsigned METRIC_W = 2;

endpackage

`default_nettype wire

### src/pdm_diff.sv
`timescale 1ns / 1ps
`default_nettype none

module pdm_diff #(
  parameter int unsigned CW = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   vld_in,
  input  wire logic signed [CW-1:0]   ax,
  input  wire logic signed [CW-1:0]   ay,
  input  wire logic signed [CW-1:0]   bx,
  input  wire logic signed [CW-1:0]   by,
  input  wire pdm_pkg::metric_t       metric_in,
  output logic                        vld_out,
  output logic [CW-1:0]               dx_out,
  output logic [CW-1:0]               dy_out,
  output pdm_pkg::metric_t            metric_out,
  output logic [CW:0]                 alt_out
);
  import pdm_pkg::*;

  logic signed [CW:0] sdx, sdy;
  logic [CW:0]        mdx, mdy;
  logic [CW-1:0]      dx_nxt, dy_nxt;
  logic [CW:0]        alt_nxt;
  logic               vld_r;
  logic [CW-1:0]      dx_r, dy_r;
  metric_t            metric_r;
  logic [CW:0]        alt_r;

  always_comb begin
    sdx = {ax[CW-1], ax} - {bx[CW-1], bx};
    sdy = {ay[CW-1], ay} - {by[CW-1], by};
    mdx = sdx[CW] ? (~sdx + 1'b1) : sdx;
    mdy = sdy[CW] ? (~sdy + 1'b1) : sdy;
    // magnitude of a CW+1 bit difference always fits CW bits
    dx_nxt = mdx[CW-1:0];
    dy_nxt = mdy[CW-1:0];
    unique case (metric_in) inside
      METRIC_MANHATTAN:                alt_nxt = {1'b0, dx_nxt} + {1'b0, dy_nxt};
      // euclid carries the larger leg for the sanity check downstream
      METRIC_EUCLID, METRIC_CHEBYSHEV: alt_nxt = (dx_nxt > dy_nxt) ? {1'b0, dx_nxt}
                                                                   : {1'b0, dy_nxt};
      default:                         alt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    metric_r <= metric_in;
    alt_r    <= alt_nxt;
  end

  assign vld_out    = vld_r;
  assign dx_out     = dx_r;
  assign dy_out     = dy_r;
  assign metric_out = metric_r;
  assign alt_out    = alt_r;

endmodule

`default_nettype wire

### src/pdm_square.sv
`timescale 1ns / 1ps
`default_nettype none

module pdm_square #(
  parameter int unsigned CW     = 16,
  parameter int unsigned SIDE_W = 19
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                vld_in,
  input  wire logic [CW-1:0]       dx,
  input  wire logic [CW-1:0]       dy,
  input  wire logic [SIDE_W-1:0]   side_in,
  output logic                     vld_out,
  output logic [2*CW:0]            sum_out,
  output logic [SIDE_W-1:0]        side_out
);
  import pdm_pkg::*;

  localparam int unsigned PW = 2 * CW;

  logic [PW-1:0]     sqx_nxt, sqy_nxt;
  logic [PW-1:0]     sqx_r, sqy_r;
  logic              vld_a_r, vld_b_r;
  logic [SIDE_W-1:0] side_a_r, side_b_r;
  logic [PW:0]       sum_nxt, sum_r;

  // stage a: the two squares
  assign sqx_nxt = {{CW{1'b0}}, dx} * {{CW{1'b0}}, dx};
  assign sqy_nxt = {{CW{1'b0}}, dy} * {{CW{1'b0}}, dy};
  // stage b: their sum
  assign sum_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r    <= sqx_nxt;
    sqy_r    <= sqy_nxt;
    side_a_r <= side_in;
    sum_r    <= sum_nxt;
    side_b_r <= side_a_r;
  end

  assign vld_out  = vld_b_r;
  assign sum_out  = sum_r;
  assign side_out = side_b_r;

endmodule

`default_nettype wire

### src/pdm_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring integer square root, one result bit per stage
module pdm_isqrt #(
  parameter int unsigned CW     = 16,
  parameter int unsigned SIDE_W = 19
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                vld_in,
  input  wire logic [2*CW:0]       radicand,
  input  wire logic [SIDE_W-1:0]   side_in,
  output logic                     vld_out,
  output logic [CW:0]              root_out,
  output logic [SIDE_W-1:0]        side_out
);
  import pdm_pkg::*;

  localparam int unsigned NW    = 2 * CW + 1;
  localparam int unsigned STEPS = CW + 1;

  logic [NW-1:0]     rem_r  [STEPS+1];
  logic [NW-1:0]     root_r [STEPS+1];
  logic              vld_r  [STEPS+1];
  logic [SIDE_W-1:0] side_r [STEPS+1];

  always_comb begin
    rem_r[0]  = radicand;
    root_r[0] = '0;
    vld_r[0]  = vld_in;
    side_r[0] = side_in;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (CW - i));

    logic [NW:0]   trial;
    logic          fits;
    logic [NW-1:0] rem_nxt, root_nxt;

    always_comb begin
      trial = {1'b0, root_r[i]} + {1'b0, BIT};
      fits  = ({1'b0, rem_r[i]} >= trial);
      if (fits) begin
        rem_nxt  = rem_r[i] - trial[NW-1:0];
        root_nxt = (root_r[i] >> 1) + BIT;
      end else begin
        rem_nxt  = rem_r[i];
        root_nxt = root_r[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i+1]  <= rem_nxt;
      root_r[i+1] <= root_nxt;
      side_r[i+1] <= side_r[i];
    end
  end

  assign vld_out  = vld_r[STEPS];
  assign root_out = root_r[STEPS][CW:0];
  assign side_out = side_r[STEPS];

  // leftover must be below (root+1)^2 - root^2
  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[STEPS] |-> (rem_r[STEPS] <= (root_r[STEPS] << 1)))
    else $error("isqrt remainder exceeds 2*root");

endmodule

`default_nettype wire

### src/point_distance_metric_top.sv
`timescale 1ns / 1ps
`default_nettype none

// point distance unit: takes two signed points per beat and returns their
// manhattan, euclidean (floor of exact integer square root) or chebyshev
// distance, selected by cfg_wdata written through cfg_we; code 3 gives zero.
// the metric is sampled when a beat is taken, so a write affects later beats.
// a beat is taken on every clock edge with start high; busy stays low, so one
// beat per cycle is sustained. each result appears on out_distance for a
// single cycle with out_strobe high, after its beat passes one stage of
// differences, two of squaring and summing, one per root bit in the square
// root pipeline and one output stage. results come out in beat order and
// the receiver cannot stall them.
module point_distance_metric_top #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_y,
  // result channel
  output logic                               out_strobe,
  output logic [COORD_WIDTH:0]               out_distance,
  // metric register
  input  wire logic                          cfg_we,
  input  wire logic [pdm_pkg::METRIC_W-1:0]  cfg_wdata
);
  import pdm_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  // sideband: metric code on top, non-root distance below
  localparam int unsigned SIDE_W = METRIC_W + CW + 1;

  metric_t             metric_r;
  logic                accept;

  // difference stage outputs
  logic                df_vld;
  logic [CW-1:0]       df_dx, df_dy;
  metric_t             df_metric;
  logic [CW:0]         df_alt;
  logic [SIDE_W-1:0]   df_side;

  // square stage outputs
  logic                sq_vld;
  logic [2*CW:0]       sq_sum;
  logic [SIDE_W-1:0]   sq_side;

  // root stage outputs
  logic                rt_vld;
  logic [CW:0]         rt_root;
  logic [SIDE_W-1:0]   rt_side;
  metric_t             rt_metric;
  logic [CW:0]         rt_alt;

  logic                out_strobe_r;
  logic [CW:0]         out_distance_r, out_distance_nxt;

  // never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_MANHATTAN;
    end else if (cfg_we) begin
      metric_r <= metric_t'(cfg_wdata);
    end
  end

  pdm_diff #(.CW(CW)) u_diff (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_in     (accept),
    .ax         (in_first_x),
    .ay         (in_first_y),
    .bx         (in_second_x),
    .by         (in_second_y),
    .metric_in  (metric_r),
    .vld_out    (df_vld),
    .dx_out     (df_dx),
    .dy_out     (df_dy),
    .metric_out (df_metric),
    .alt_out    (df_alt)
  );

  assign df_side = {df_metric, df_alt};

  pdm_square #(.CW(CW), .SIDE_W(SIDE_W)) u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (df_vld),
    .dx       (df_dx),
    .dy       (df_dy),
    .side_in  (df_side),
    .vld_out  (sq_vld),
    .sum_out  (sq_sum),
    .side_out (sq_side)
  );

  pdm_isqrt #(.CW(CW), .SIDE_W(SIDE_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (sq_vld),
    .radicand (sq_sum),
    .side_in  (sq_side),
    .vld_out  (rt_vld),
    .root_out (rt_root),
    .side_out (rt_side)
  );

  assign rt_metric = metric_t'(rt_side[SIDE_W-1 -: METRIC_W]);
  assign rt_alt    = rt_side[CW:0];

  // euclid takes the root, every other code takes the carried value
  always_comb begin
    unique case (rt_metric) inside
      METRIC_EUCLID:                                   out_distance_nxt = rt_root;
      METRIC_MANHATTAN, METRIC_CHEBYSHEV, METRIC_NONE: out_distance_nxt = rt_alt;
      default:                                         out_distance_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_distance_r <= out_distance_nxt;
  end

  assign out_strobe   = out_strobe_r;
  assign out_distance = out_distance_r;

  // the hypotenuse is never shorter than the longer leg
  a_euclid_floor : assert property (@(posedge clk) disable iff (!rst_n)
    (rt_vld && rt_metric == METRIC_EUCLID) |-> (rt_root >= rt_alt))
    else $error("euclid root below longer leg");

  // unknown metric beats travel as zero all the way down
  a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (rt_vld && rt_metric == METRIC_NONE) |=> (out_strobe && out_distance == '0))
    else $error("unknown metric beat gave nonzero distance");

  // no stale beat escapes the pipe right after reset
  a_quiet_after_reset : assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_strobe)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire
